// ----- rtl/oaht_pkg.sv -----
// Shared types and codes for the open addressing hash table core.
// No dependencies; used by every module of the block but oaht_ram.
`default_nettype none
package oaht_pkg;

   localparam int KEY_W     = 64;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 32;
   localparam int HOME_W    = 16;
   localparam int TSIZE_W   = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE = 1'd1;

   localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1021;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [KEY_W-1:0]  key_chars;
      logic [LEN_W-1:0]  key_length;
      logic [DATA_W-1:0] record_data;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [9:0]        slot;
      logic [9:0]        home_slot;
      logic [10:0]       probe_count;
      logic [DATA_W-1:0] found_data;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [KEY_W-1:0]  key;
      logic [LEN_W-1:0]  len;
      logic [HOME_W-1:0] home;
      logic [DATA_W-1:0] data;
   } task_type;

endpackage
`default_nettype wire

// ----- rtl/open_addressing_hash_table_core.sv -----
// Open addressing hash table core. The front end hashes the key and reduces it modulo the
// size, the command waits in the queue, and the back end reads and checks one slot per probe
// and strobes the result; clear skips the hash and sweeps every slot. A new transaction is
// taken once the front end has pushed the last one, while the back end may still be busy.
// After reset a clearing pass over every slot runs with busy high; the receiver cannot stall.
// Depends on oaht_pkg, oaht_front, oaht_queue, oaht_back.
`default_nettype none
module open_addressing_hash_table_core #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int MAX_KEY_CHARS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire oaht_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   output oaht_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [oaht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [oaht_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   localparam int SW = $clog2(TABLE_DEPTH + 1);

   logic [oaht_pkg::TSIZE_W-1:0] table_size_ff;
   logic                         probe_mode_ff;
   logic [SW-1:0]                size;
   logic                         fbusy, init_done, push, pop, q_full, q_empty;
   oaht_pkg::task_type           push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= oaht_pkg::TSIZE_RESET;
         probe_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            oaht_pkg::CSR_TABLE_SIZE: table_size_ff <= csr_wdata[oaht_pkg::TSIZE_W-1:0];
            oaht_pkg::CSR_PROBE_MODE: probe_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(table_size_ff) < 32'd2) begin
         size = SW'(2);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         size = SW'(TABLE_DEPTH);
      end else begin
         size = SW'(table_size_ff);
      end
   end

   assign busy = fbusy || !init_done;

   oaht_front #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_KEY_CHARS(MAX_KEY_CHARS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start && !busy),
      .req_data  (req_data),
      .fbusy     (fbusy),
      .size      (size),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   oaht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_empty   (q_empty)
   );

   oaht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .size      (size),
      .quad      (probe_mode_ff),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_empty   (q_empty),
      .init_done (init_done),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

// ----- rtl/oaht_ram.sv -----
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- rtl/oaht_front.sv -----
// Front end: accepts commands, hashes the key and reduces it modulo the size (clear skips both).
// Depends on oaht_pkg.
`default_nettype none
module oaht_front #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int MAX_KEY_CHARS = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire oaht_pkg::req_type                req_data,
   output logic                                  fbusy,
   input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] size,
   output logic                                  push,
   output oaht_pkg::task_type                    push_data,
   input  wire logic                             q_full
);
   localparam int SW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_HASH = 4'b0010,
      F_MOD  = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   fstate_type                    state_ff, state_in;
   oaht_pkg::task_type            task_ff, task_in;
   logic [63:0]                   prod_ff, prod_in;
   logic [3:0]                    cnt_ff, cnt_in;
   logic [5:0]                    bit_ff, bit_in;
   logic [SW-1:0]                 rem_ff, rem_in;
   logic [SW:0]                   trial;
   logic [oaht_pkg::LEN_W-1:0]    len_cl;
   logic [oaht_pkg::KEY_W-1:0]    key_m;
   logic [1:0]                    op_n;

   always_comb begin
      len_cl = (req_data.key_length > oaht_pkg::LEN_W'(MAX_KEY_CHARS))
               ? oaht_pkg::LEN_W'(MAX_KEY_CHARS) : req_data.key_length;
      for (int c = 0; c < 8; c++) begin
         key_m[c*8 +: 8] = (oaht_pkg::LEN_W'(c) < len_cl) ? req_data.key_chars[c*8 +: 8]
                                                           : 8'd0;
      end
      if (req_data.op == oaht_pkg::OP_CLEAR || req_data.op == oaht_pkg::OP_INSERT) begin
         op_n = req_data.op;
      end else begin
         op_n = oaht_pkg::OP_LOOKUP;
      end
      trial = {rem_ff, prod_ff[bit_ff]};
   end

   always_comb begin
      state_in = state_ff;
      task_in  = task_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               task_in.op   = op_n;
               task_in.key  = key_m;
               task_in.len  = len_cl;
               task_in.data = req_data.record_data;
               task_in.home = '0;
               prod_in      = 64'd1;
               cnt_in       = '0;
               state_in     = (op_n == oaht_pkg::OP_CLEAR) ? F_PUSH : F_HASH;
            end
         end
         F_HASH: begin
            if (cnt_ff == task_ff.len) begin
               bit_in   = 6'd63;
               rem_in   = '0;
               state_in = F_MOD;
            end else begin
               prod_in = prod_ff * {56'd0, task_ff.key[cnt_ff[2:0]*8 +: 8]};
               cnt_in  = cnt_ff + 4'd1;
            end
         end
         F_MOD: begin
            rem_in = (trial >= {1'b0, size}) ? SW'(trial - {1'b0, size}) : SW'(trial);
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd0) begin
               task_in.home = oaht_pkg::HOME_W'(rem_in);
               state_in     = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      task_ff <= task_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
   end

   assign fbusy     = (state_ff != F_IDLE);
   assign push_data = task_ff;
endmodule
`default_nettype wire

// ----- rtl/oaht_queue.sv -----
// Two-entry queue of classified commands between front and back end.
// Depends on oaht_pkg.
`default_nettype none
module oaht_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire oaht_pkg::task_type push_data,
   output logic                    q_full,
   input  wire logic               pop,
   output oaht_pkg::task_type      pop_data,
   output logic                    q_empty
);
   oaht_pkg::task_type entry_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

   assign q_full   = (cnt_ff == 2'd2);
   assign q_empty  = (cnt_ff == 2'd0);
   assign pop_data = entry_ff[rp_ff];
endmodule
`default_nettype wire

// ----- rtl/oaht_back.sv -----
// Back end: probe walk, insert, lookup and clear over the slot RAM.
// Depends on oaht_pkg and oaht_ram.
`default_nettype none
module oaht_back #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] size,
   input  wire logic                             quad,
   output logic                                  pop,
   input  wire oaht_pkg::task_type               pop_data,
   input  wire logic                             q_empty,
   output logic                                  init_done,
   output logic                                  rsp_valid,
   output oaht_pkg::rsp_type                     rsp_data
);
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int SW   = $clog2(TABLE_DEPTH + 1);
   localparam int CW   = $clog2(TABLE_DEPTH + 2);
   localparam int EW   = 1 + oaht_pkg::KEY_W + oaht_pkg::LEN_W + AW + oaht_pkg::DATA_W;

   typedef enum logic [4:0] {
      B_INIT  = 5'b00001,
      B_IDLE  = 5'b00010,
      B_READ  = 5'b00100,
      B_CHECK = 5'b01000,
      B_CLEAR = 5'b10000
   } bstate_type;

   bstate_type          state_ff, state_in;
   oaht_pkg::task_type  task_ff, task_in;
   logic [CW-1:0]       step_ff, step_in, step1;
   logic [AW-1:0]       off_ff, off_in, dq_ff, dq_in, slot_ff, slot_in, sweep_ff, sweep_in;
   logic [AW-1:0]       home, slot_cur;
   logic [SW:0]         sum, osum, dsum;
   logic                rsp_valid_ff, rsp_valid_in;
   oaht_pkg::rsp_type   rsp_ff, rsp_in;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data, rd_data;
   logic                occ, match;

   oaht_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (slot_cur),
      .rd_data (rd_data)
   );

   always_comb begin
      home     = AW'(task_ff.home);
      sum      = (SW+1)'(home) + (SW+1)'(off_ff);
      slot_cur = (sum >= (SW+1)'(size)) ? AW'(sum - (SW+1)'(size)) : AW'(sum);
      osum     = (SW+1)'(off_ff) + (SW+1)'(dq_ff);
      dsum     = (SW+1)'(dq_ff) + (SW+1)'(2);
      step1    = step_ff + CW'(1);
      occ      = rd_data[EW-1];
      match    = (rd_data[EW-2 -: oaht_pkg::KEY_W] == task_ff.key)
              && (rd_data[EW-2-oaht_pkg::KEY_W -: oaht_pkg::LEN_W] == task_ff.len);
   end

   always_comb begin
      state_in     = state_ff;
      task_in      = task_ff;
      step_in      = step_ff;
      off_in       = off_ff;
      dq_in        = dq_ff;
      slot_in      = slot_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      unique case (state_ff) inside
         B_INIT, B_CLEAR: begin
            wr_en    = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = B_IDLE;
               if (state_ff == B_CLEAR) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.status = oaht_pkg::ST_CLEARED;
               end
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               task_in  = pop_data;
               step_in  = '0;
               off_in   = '0;
               dq_in    = AW'(1);
               sweep_in = '0;
               state_in = (pop_data.op == oaht_pkg::OP_CLEAR) ? B_CLEAR : B_READ;
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            slot_in  = slot_cur;
            state_in = B_CHECK;
         end
         B_CHECK: begin
            rsp_in            = '0;
            rsp_in.home_slot  = 10'(home);
            if (task_ff.op == oaht_pkg::OP_INSERT) begin
               if (!occ) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_ff;
                  wr_data = {1'b1, task_ff.key, task_ff.len, home, task_ff.data};
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = oaht_pkg::ST_INSERTED;
                  rsp_in.slot        = 10'(slot_ff);
                  rsp_in.probe_count = 11'(step1);
                  state_in           = B_IDLE;
               end else if (step1 == CW'(size)) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = oaht_pkg::ST_FULL;
                  rsp_in.probe_count = 11'(size);
                  state_in           = B_IDLE;
               end else begin
                  state_in = B_READ;
               end
            end else begin
               if (!occ) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = oaht_pkg::ST_NOT_FOUND;
                  rsp_in.probe_count = 11'(step1);
                  state_in           = B_IDLE;
               end else if (match) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = oaht_pkg::ST_FOUND;
                  rsp_in.slot        = 10'(slot_ff);
                  rsp_in.probe_count = 11'(step1);
                  rsp_in.found_data  = rd_data[oaht_pkg::DATA_W-1:0];
                  state_in           = B_IDLE;
               end else if (step1 == CW'(size)) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = oaht_pkg::ST_NOT_FOUND;
                  rsp_in.probe_count = 11'(step1 + CW'(1));
                  state_in           = B_IDLE;
               end else begin
                  state_in = B_READ;
               end
            end
            step_in = step1;
            off_in  = (osum >= (SW+1)'(size)) ? AW'(osum - (SW+1)'(size)) : AW'(osum);
            if (quad) begin
               dq_in = (dsum >= (SW+1)'(size)) ? AW'(dsum - (SW+1)'(size)) : AW'(dsum);
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      task_ff <= task_in;
      step_ff <= step_in;
      off_ff  <= off_in;
      dq_ff   <= dq_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   assign init_done = (state_ff != B_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ----- rtl/oaht_checker.sv -----
// Port-level checks for the hash table core, bound to the top level.
// Depends on oaht_pkg.
`default_nettype none
module oaht_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire oaht_pkg::rsp_type rsp_data
);
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after accepted transaction");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy) else $error("busy low right after reset");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == oaht_pkg::ST_CLEARED) |->
      (rsp_data.slot == '0 && rsp_data.home_slot == '0 && rsp_data.probe_count == '0))
      else $error("clear result carries nonzero fields");

   a_data_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != oaht_pkg::ST_FOUND) |-> rsp_data.found_data == '0)
      else $error("payload on a result other than found");
endmodule

bind open_addressing_hash_table_core oaht_checker u_oaht_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
